@@ src/hrot_pkg.sv @@
// Shared types and constants for the RGB hue rotation pipeline.
// No dependencies; used by every module under src except hrot_div.
`default_nettype none
package hrot_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DEG60         = 960;
  localparam int DEG360        = 5760;
  localparam int SHIFT_W       = 14;   // hue_shift port width
  localparam int SHMOD_W       = 13;   // reduced shift, 0..5759
  localparam int A_W           = 18;   // 960 * |num|
  localparam int CH_W          = 8;

  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } base_sel_t;

  // side data riding with the hue divider
  typedef struct packed {
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] delta;
    base_sel_t       sel;
    logic            neg;
  } front_side_t;

  // side data riding with the divide-by-15 pipe
  typedef struct packed {
    logic [CH_W-1:0] mn;
    logic [CH_W-1:0] c;
    logic [2:0]      k;
  } back_side_t;

endpackage
`default_nettype wire

@@ src/hrot_front.sv @@
// Input stage: max, min, delta and hue numerator of one pixel.
// Depends on hrot_pkg.
`default_nettype none
module hrot_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     valid_in,
  input  wire logic [7:0]               r,
  input  wire logic [7:0]               g,
  input  wire logic [7:0]               b,
  output logic                          valid,
  output hrot_pkg::front_side_t         side,
  output logic [hrot_pkg::A_W-1:0]      num_a
);

  logic [7:0] mx, mn, an;
  logic       ng;
  hrot_pkg::base_sel_t sel;

  always_comb begin
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (mx == r) begin
      sel = hrot_pkg::BASE_RED;
      ng  = g < b;
      an  = ng ? b - g : g - b;
    end else if (mx == g) begin
      sel = hrot_pkg::BASE_GREEN;
      ng  = b < r;
      an  = ng ? r - b : b - r;
    end else begin
      sel = hrot_pkg::BASE_BLUE;
      ng  = r < g;
      an  = ng ? g - r : r - g;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      side.mn    <= mn;
      side.delta <= mx - mn;
      side.sel   <= sel;
      side.neg   <= ng;
      num_a      <= hrot_pkg::A_W'(an) * hrot_pkg::A_W'(hrot_pkg::DEG60);
    end
  end

endmodule
`default_nettype wire

@@ src/hrot_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing but its parameters; carries an opaque side vector.
`default_nettype none
module hrot_div #(
  parameter int NW = 34,
  parameter int DW = 8,
  parameter int QW = 26,
  parameter int SW = 19
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          valid_in,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               valid,
  output logic [QW-1:0]      quot,
  output logic [SW-1:0]      side
);

  logic          v_r   [NW];
  logic [NW-1:0] n_r   [NW];
  logic [DW-1:0] d_r   [NW];
  logic [DW-1:0] rem_r [NW];
  logic [QW-1:0] q_r   [NW];
  logic [SW-1:0] s_r   [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic          v_p;
    logic [NW-1:0] n_p;
    logic [DW-1:0] d_p;
    logic [DW-1:0] rem_p;
    logic [QW-1:0] q_p;
    logic [SW-1:0] s_p;
    logic [DW:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_p   = valid_in;
      assign n_p   = dividend;
      assign d_p   = divisor;
      assign rem_p = '0;
      assign q_p   = '0;
      assign s_p   = side_in;
    end else begin : g_next
      assign v_p   = v_r[j-1];
      assign n_p   = n_r[j-1];
      assign d_p   = d_r[j-1];
      assign rem_p = rem_r[j-1];
      assign q_p   = q_r[j-1];
      assign s_p   = s_r[j-1];
    end

    assign trial = {rem_p, n_p[NW-1]};
    assign ge    = trial >= {1'b0, d_p};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_p;
      end
      if (en) begin
        n_r[j]   <= n_p << 1;
        d_r[j]   <= d_p;
        rem_r[j] <= ge ? DW'(trial - {1'b0, d_p}) : trial[DW-1:0];
        q_r[j]   <= {q_p[QW-2:0], ge};
        s_r[j]   <= s_p;
      end
    end
  end

  assign valid = v_r[NW-1];
  assign quot  = q_r[NW-1];
  assign side  = s_r[NW-1];

endmodule
`default_nettype wire

@@ src/hrot_hue.sv @@
// Hue assembly, shift, sextant split and chroma product (four stages).
// Depends on hrot_pkg.
`default_nettype none
module hrot_hue #(
  parameter int FRAC_BITS = hrot_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          valid_in,
  input  wire logic [FRAC_BITS+9:0]          t,
  input  wire hrot_pkg::front_side_t         side_in,
  input  wire logic [hrot_pkg::SHMOD_W-1:0]  sh_mod,
  output logic                               valid,
  output logic [FRAC_BITS+11:0]              y,
  output hrot_pkg::back_side_t               side
);

  localparam int HW = FRAC_BITS + 13;
  localparam int GW = FRAC_BITS + 10;
  localparam logic [HW-1:0] FULL = HW'(hrot_pkg::DEG360) << FRAC_BITS;
  localparam logic [HW-1:0] SEXT = HW'(hrot_pkg::DEG60) << FRAC_BITS;

  logic [3:0]            v;
  logic [HW-1:0]         h0, h1;
  logic [GW-1:0]         gsel;
  logic [2:0]            k2;
  logic [hrot_pkg::CH_W-1:0] mn [4];
  logic [hrot_pkg::CH_W-1:0] c  [4];
  logic [2:0]            k3;

  logic [HW-1:0] base, h0_next, h1_next, f;
  logic [HW:0]   h1_sum;
  logic [2:0]    k_next;

  always_comb begin
    case (side_in.sel)
      hrot_pkg::BASE_GREEN: base = HW'(1920) << FRAC_BITS;
      hrot_pkg::BASE_BLUE:  base = HW'(3840) << FRAC_BITS;
      default:              base = '0;
    endcase
    if (side_in.neg) h0_next = ((base == '0) ? FULL : base) - HW'(t);
    else             h0_next = base + HW'(t);
    if (h0_next >= FULL) h0_next = h0_next - FULL;
    if (side_in.delta == '0) h0_next = '0;

    // hue and shift are each below one turn, so the sum needs one extra bit
    h1_sum  = {1'b0, h0} + ((HW+1)'(sh_mod) << FRAC_BITS);
    h1_next = (h1_sum >= {1'b0, FULL}) ? HW'(h1_sum - {1'b0, FULL}) : h1_sum[HW-1:0];

    if      (h1 >= HW'(5) * SEXT) k_next = 3'd5;
    else if (h1 >= HW'(4) * SEXT) k_next = 3'd4;
    else if (h1 >= HW'(3) * SEXT) k_next = 3'd3;
    else if (h1 >= HW'(2) * SEXT) k_next = 3'd2;
    else if (h1 >= SEXT)          k_next = 3'd1;
    else                          k_next = 3'd0;
    f = h1 - HW'(k_next) * SEXT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], valid_in};
    end
    if (en) begin
      h0    <= h0_next;
      mn[0] <= side_in.mn;
      c[0]  <= side_in.delta;
      h1    <= h1_next;
      mn[1] <= mn[0];
      c[1]  <= c[0];
      k2    <= k_next;
      gsel  <= k_next[0] ? GW'(SEXT - f) : GW'(f);
      mn[2] <= mn[1];
      c[2]  <= c[1];
      y     <= (FRAC_BITS+12)'((GW+8)'(c[2]) * (GW+8)'(gsel) >> 6);
      k3    <= k2;
      mn[3] <= mn[2];
      c[3]  <= c[2];
    end
  end

  assign valid   = v[3];
  assign side.mn = mn[3];
  assign side.c  = c[3];
  assign side.k  = k3;

endmodule
`default_nettype wire

@@ src/hrot_back.sv @@
// Divide by 15 through a reciprocal product, channel rebuild from chroma, x
// and offset, rounding and the output register. Depends on hrot_pkg.
`default_nettype none
module hrot_back #(
  parameter int FRAC_BITS = hrot_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  valid_in,
  input  wire logic [FRAC_BITS+11:0] y,
  input  wire hrot_pkg::back_side_t  side_in,
  output logic                       valid,
  output logic [7:0]                 r,
  output logic [7:0]                 g,
  output logic [7:0]                 b
);

  localparam int VW = FRAC_BITS + 10;
  localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);

  // x = floor(y / 15) = floor(y * RECIP >> SH); exact for y <= 3825 << FRAC_BITS
  localparam int YW = FRAC_BITS + 12;
  localparam int YL = YW / 2;
  localparam int YH = YW - YL;
  localparam int SH = FRAC_BITS + 16;
  localparam int MW = SH - 3;
  localparam int PW = YW + MW;
  localparam int XW = FRAC_BITS + 8;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'd14) / 64'd15);

  logic                 va, vb;
  logic [YL+MW-1:0]     pl;
  logic [YH+MW-1:0]     ph;
  hrot_pkg::back_side_t side_a, side_b;
  logic [XW-1:0]        x;
  logic [PW-1:0]        prod;

  logic [VW-1:0] cf, xf, mf;
  logic [VW-1:0] ch [3];
  logic [7:0]    res [3];

  always_comb begin
    prod = PW'(pl) + (PW'(ph) << YL);

    cf = VW'(side_b.c) << FRAC_BITS;
    xf = VW'(x);
    mf = VW'(side_b.mn) << FRAC_BITS;
    case (side_b.k)
      3'd0:    begin ch[0] = cf; ch[1] = xf; ch[2] = '0; end
      3'd1:    begin ch[0] = xf; ch[1] = cf; ch[2] = '0; end
      3'd2:    begin ch[0] = '0; ch[1] = cf; ch[2] = xf; end
      3'd3:    begin ch[0] = '0; ch[1] = xf; ch[2] = cf; end
      3'd4:    begin ch[0] = xf; ch[1] = '0; ch[2] = cf; end
      default: begin ch[0] = cf; ch[1] = '0; ch[2] = xf; end
    endcase
    for (int i = 0; i < 3; i++) begin
      logic [VW-1:0] s;
      s = (ch[i] + mf + HALF) >> FRAC_BITS;
      res[i] = (s > VW'(255)) ? 8'd255 : s[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      va    <= valid_in;
      vb    <= va;
      valid <= vb;
    end
    if (en) begin
      // split the reciprocal product into two halves of y
      pl     <= (YL+MW)'(y[YL-1:0]) * (YL+MW)'(RECIP);
      ph     <= (YH+MW)'(y[YW-1:YL]) * (YH+MW)'(RECIP);
      side_a <= side_in;
      x      <= prod[SH+XW-1:SH];
      side_b <= side_a;
      r      <= res[0];
      g      <= res[1];
      b      <= res[2];
    end
  end

endmodule
`default_nettype wire

@@ src/rgb_hue_rotate_core.sv @@
// Top level of the RGB hue rotation pipeline.
// Depends on hrot_pkg, hrot_front, hrot_div, hrot_hue, hrot_back.
`default_nettype none
//
//  channel   | signals                                   | beat
//  ----------+-------------------------------------------+---------------------
//  pixel in  | in_valid, in_ready, red/green/blue_in     | in_valid & in_ready
//  pixel out | out_valid, out_ready, red/green/blue_out  | out_valid & out_ready
//  config    | hue_shift_we, hue_shift                   | hue_shift_we
//
//  One pixel per clock sustained while the output side takes every beat. The
//  pipe holds 1 input stage, 18 + FRAC_BITS hue divider stages, 4 hue
//  stages, 2 reciprocal stages for the divide by 15 and the output register.
//  The bit-per-stage hue divider sets the depth.
//  Reset clears all valid bits and the shift register (shift 0).
//  A stall holds the whole pipe: every stage advances only while the output
//  register is empty or its beat is taken.
module rgb_hue_rotate_core #(
  parameter int FRAC_BITS = hrot_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  input  wire logic                          hue_shift_we,
  input  wire logic [hrot_pkg::SHIFT_W-1:0]  hue_shift
);

  localparam int NW1 = hrot_pkg::A_W + FRAC_BITS;
  localparam int QW1 = FRAC_BITS + 10;
  localparam int NW2 = FRAC_BITS + 12;
  localparam int S1W = $bits(hrot_pkg::front_side_t);

  // Reduced shift, kept in 0..5759 so the hue stage needs a single wrap.
  logic [hrot_pkg::SHMOD_W-1:0] sh_mod;
  logic signed [hrot_pkg::SHIFT_W+1:0] shv, shv_red;

  always_comb begin
    shv = (hrot_pkg::SHIFT_W+2)'(signed'(hue_shift));
    if (shv < -16'sd5760)      shv_red = shv + 16'sd11520;
    else if (shv < 16'sd0)     shv_red = shv + 16'sd5760;
    else if (shv >= 16'sd5760) shv_red = shv - 16'sd5760;
    else                       shv_red = shv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_mod <= '0;
    end else if (hue_shift_we) begin
      sh_mod <= shv_red[hrot_pkg::SHMOD_W-1:0];
    end
  end

  // Global advance: hold everything while a finished beat waits.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic                      f_valid;
  hrot_pkg::front_side_t     f_side;
  logic [hrot_pkg::A_W-1:0]  f_num;

  hrot_front u_front (
    .clk, .rst, .en,
    .valid_in (in_valid && in_ready),
    .r        (red_in),
    .g        (green_in),
    .b        (blue_in),
    .valid    (f_valid),
    .side     (f_side),
    .num_a    (f_num)
  );

  logic                  d1_valid;
  logic [QW1-1:0]        d1_q;
  logic [S1W-1:0]        d1_side;

  // t = (960*|num| << FRAC_BITS) / delta
  hrot_div #(.NW(NW1), .DW(8), .QW(QW1), .SW(S1W)) u_div_hue (
    .clk, .rst, .en,
    .valid_in (f_valid),
    .dividend ({f_num, {FRAC_BITS{1'b0}}}),
    .divisor  (f_side.delta),
    .side_in  (S1W'(f_side)),
    .valid    (d1_valid),
    .quot     (d1_q),
    .side     (d1_side)
  );

  logic                  h_valid;
  logic [NW2-1:0]        h_y;
  hrot_pkg::back_side_t  h_side;

  hrot_hue #(.FRAC_BITS(FRAC_BITS)) u_hue (
    .clk, .rst, .en,
    .valid_in (d1_valid),
    .t        (d1_q),
    .side_in  (hrot_pkg::front_side_t'(d1_side)),
    .sh_mod   (sh_mod),
    .valid    (h_valid),
    .y        (h_y),
    .side     (h_side)
  );

  // x = (c*f >> 6) / 15, i.e. c*f / 960, then rebuild the channels
  hrot_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .en,
    .valid_in (h_valid),
    .y        (h_y),
    .side_in  (h_side),
    .valid    (out_valid),
    .r        (red_out),
    .g        (green_out),
    .b        (blue_out)
  );

  // A waiting beat must freeze the input side.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // Reset empties the pipe.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Reduced shift stays within one turn.
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    sh_mod < hrot_pkg::SHMOD_W'(hrot_pkg::DEG360))
    else $error("reduced hue shift out of range");

endmodule
`default_nettype wire

@@ bench/rgb_hue_rotate_core_test.sv @@
// Self-checking bench for rgb_hue_rotate_core: random pixels through a bit-exact
// fixed-point hue predictor, with bursty input and a stalling output side.
// Depends on hrot_pkg and the RTL under src.
module rgb_hue_rotate_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = hrot_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = FB + 26;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  int error_count = 0;

  // Print one line per mismatch and count it.
  task automatic report(string what, pixel_t got, pixel_t want);
    $display("MISMATCH %s: got %0d/%0d/%0d want %0d/%0d/%0d", what,
             got.r, got.g, got.b, want.r, want.g, want.b);
    error_count++;
  endtask

  function automatic logic [7:0] round_chan(longint unsigned v);
    longint unsigned q;
    q = (v + (64'd1 << (FB - 1))) >> FB;
    return q > 255 ? 8'd255 : q[7:0];
  endfunction

  // Rotate one pixel with the current shift, same integer math as the block.
  function automatic pixel_t rotate_pixel(pixel_t p, logic signed [13:0] shift);
    longint unsigned full, sext, hue, base, t, c, m, x, f, a, bb, cc;
    int r, g, b, mx, mn, delta, num, sh, k;
    pixel_t o;
    full = longint'(hrot_pkg::DEG360) << FB;
    sext = longint'(hrot_pkg::DEG60) << FB;
    r = p.r; g = p.g; b = p.b;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue = 0;
    if (delta != 0) begin
      if (mx == r) begin
        num = g - b; base = 0;
      end else if (mx == g) begin
        num = b - r; base = 64'd1920 << FB;
      end else begin
        num = r - g; base = 64'd3840 << FB;
      end
      t = ((longint'(hrot_pkg::DEG60) * (num < 0 ? -num : num)) << FB) / delta;
      if (num >= 0) hue = base + t;
      else hue = (base == 0 ? full : base) - t;
      if (hue >= full) hue -= full;
    end
    sh = int'(shift) % hrot_pkg::DEG360;
    if (sh < 0) sh += hrot_pkg::DEG360;
    hue += longint'(sh) << FB;
    if (hue >= full) hue -= full;
    c = delta;
    m = longint'(mn) << FB;
    k = int'(hue / sext);
    if (k > 5) k = 5;
    f = hue - k * sext;
    if (k & 1) x = (c * (sext - f)) / hrot_pkg::DEG60;
    else x = (c * f) / hrot_pkg::DEG60;
    c = c << FB;
    case (k)
      0: begin a = c; bb = x; cc = 0; end
      1: begin a = x; bb = c; cc = 0; end
      2: begin a = 0; bb = c; cc = x; end
      3: begin a = 0; bb = x; cc = c; end
      4: begin a = x; bb = 0; cc = c; end
      default: begin a = c; bb = 0; cc = x; end
    endcase
    o.r = round_chan(a + m);
    o.g = round_chan(bb + m);
    o.b = round_chan(cc + m);
    return o;
  endfunction

  // Holds predicted pixels in acceptance order and checks arrivals against them.
  class pixel_board;
    pixel_t pending[$];
    logic signed [13:0] shift = 0;
    function void note_pixel(pixel_t p);
      pending.push_back(rotate_pixel(p, shift));
    endfunction
    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        report("unexpected beat", got, got);
        return;
      end
      want = pending.pop_front();
      if (got.r !== want.r) report("red", got, want);
      if (got.g !== want.g) report("green", got, want);
      if (got.b !== want.b) report("blue", got, want);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] red_in = 0, green_in = 0, blue_in = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] red_out, green_out, blue_out;
  logic hue_shift_we = 0;
  logic [hrot_pkg::SHIFT_W-1:0] hue_shift = 0;

  pixel_board board = new();
  bit hold_off = 0;   // set while the long receiver stall is wanted

  rgb_hue_rotate_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .hue_shift_we(hue_shift_we), .hue_shift(hue_shift)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Monitor: note accepted input beats and check accepted output beats.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_pixel('{red_in, green_in, blue_in});
      if (out_valid && out_ready) board.check_pixel('{red_out, green_out, blue_out});
    end
  end

  // Receiver: stall pattern of its own, plus the long hold-off on request.
  initial begin
    int mode;
    forever begin
      @(posedge clk);
      mode = ($time / 20000) % 4;  // pick the stall density from the simulation time
      if (hold_off) out_ready <= 0;
      else if (mode == 0) out_ready <= 1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else if (mode == 2) out_ready <= 1'($urandom_range(0, 1));
      else out_ready <= ($urandom_range(0, 4) == 0);
    end
  end

  // Offer one pixel and hold it until the beat is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_valid <= 1;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // With a nonzero argument, lower valid after the last beat of a burst and idle a while.
  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Drain every expected beat, then let the pipe settle.
  task automatic drain;
    int guard;
    in_valid <= 0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write the shift register while the pipe is empty.
  task automatic write_shift(logic signed [13:0] value);
    drain();
    hue_shift_we <= 1;
    hue_shift <= value;
    @(posedge clk);
    board.shift = value;
    hue_shift_we <= 0;
  endtask

  task automatic random_pixels(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        case ($urandom_range(0, 5))
          0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
          1: begin
            // gray pixel
            logic [7:0] v;
            v = 8'($urandom);
            send_pixel(v, v, v);
          end
          2: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0,
                        $urandom_range(0, 1) ? 8'd255 : 8'd0, 8'($urandom));
          default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        endcase
        sent++;
      end
      if ($urandom_range(0, 2) == 0) idle_gap(0);
      else idle_gap($urandom_range(1, 12));
    end
  endtask

  initial begin
    logic signed [13:0] shifts[6];
    shifts = '{14'sd0, 14'sd5760, -14'sd5760, 14'sd8191, -14'sd8192, 14'sd960};
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: primaries, secondaries, gray, extremes, each sextant.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd10, 8'd200);
    send_pixel(8'd200, 8'd255, 8'd1);
    send_pixel(8'd1, 8'd2, 8'd254);
    write_shift(14'sd2880);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd77, 8'd77, 8'd77);
    send_pixel(8'd12, 8'd240, 8'd99);
    write_shift(-14'sd8192);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd0, 8'd128, 8'd255);
    write_shift(14'sd8191);
    send_pixel(8'd255, 8'd128, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd255);

    // Pressure: hold the receiver off while the sender keeps offering.
    hold_off = 1;
    fork
      begin
        int n;
        for (n = 0; n < 300; n++) @(posedge clk);
        hold_off = 0;
      end
      repeat (150) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    join

    // Random phases across several shift settings.
    foreach (shifts[i]) begin
      write_shift(shifts[i]);
      random_pixels(170);
    end
    write_shift(14'($urandom));
    random_pixels(160);
    drain();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog well above the slowest legal run.
  initial begin
    #(20ns * 2000000);
    $display("Test completed with failures");
    $finish;
  end
endmodule

@@ sim.f @@
src/hrot_pkg.sv
src/hrot_front.sv
src/hrot_div.sv
src/hrot_hue.sv
src/hrot_back.sv
src/rgb_hue_rotate_core.sv
bench/rgb_hue_rotate_core_test.sv
